[src/rde_pkg.sv]
// Package for the resizable deque engine: request/response payload types,
// opcodes, status codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_TAIL  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_HEAD   = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_RESIZE     = 3'd4,
        OP_READ       = 3'd5,
        OP_WRITE      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    typedef enum logic [1:0] {
        ADDR_BACK,
        ADDR_FRONT_DEC,
        ADDR_INDEX
    } addr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_LOAD
    } cnt_op_t;

    typedef enum logic [1:0] {
        FR_HOLD,
        FR_DEC,
        FR_INC
    } front_op_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [9:0]         index;
        logic [10:0]        new_size;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         status;
        logic [10:0]        size_now;
    } rsp_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic nsz_over;   // new_size > capacity
        logic nsz_gt;     // new_size > count
        logic idx_lt;     // index < count
        logic idx_over;   // index >= capacity
        logic idx_gt;     // index > count
    } dp_status_t;

    // controller -> datapath
    typedef struct packed {
        logic      take_req;
        logic      mem_we;
        logic      mem_re;
        addr_sel_t addr_sel;
        logic      wr_zero;
        cnt_op_t   cnt_op;
        front_op_t front_op;
        logic      load_rsp;
        status_t   rsp_status;
        logic      rsp_use_rd;
    } cmd_t;

endpackage

`default_nettype wire

[src/rde_dp.sv]
// Deque datapath: request register, front pointer, element count, ring store
// memory, read data register and response register. Uses rde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rde_dp #(
    parameter int CAPACITY  = 1024,
    parameter int WORD_BITS = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rde_pkg::req_t       req,
    input  rde_pkg::cmd_t       cmd,
    output rde_pkg::dp_status_t status,
    output rde_pkg::rsp_t       rsp
);

    localparam int PW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 11) ? CW : 11;
    localparam int SW = XW + 1;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
    localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
    localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);

    rde_pkg::req_t          req_reg;
    logic [PW-1:0]          front_reg;
    logic [PW-1:0]          front_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [WORD_BITS-1:0]   rd_reg;
    rde_pkg::rsp_t          rsp_reg;

    logic [WORD_BITS-1:0]   mem [CAPACITY];

    logic [XW-1:0]          count_x;
    logic [XW-1:0]          idx_x;
    logic [XW-1:0]          nsz_x;
    logic [XW-1:0]          pos_x;
    logic [SW-1:0]          sum;
    logic [PW-1:0]          slot_pos;
    logic [PW-1:0]          slot_one;
    logic [SW-1:0]          sum_one;
    logic [PW-1:0]          front_dec;
    logic [PW-1:0]          addr;
    logic [WORD_BITS-1:0]   word;
    logic [WORD_BITS-1:0]   wdata;
    logic [63:0]            rd_wide;

    assign count_x = XW'(count_reg);
    assign idx_x   = XW'(req_reg.index);
    assign nsz_x   = XW'(req_reg.new_size);

    always_comb
    begin
        status.op       = rde_pkg::op_t'(req_reg.op);
        status.full     = (count_x >= CAP_X);
        status.empty    = (count_reg == '0);
        status.nsz_over = (nsz_x > CAP_X);
        status.nsz_gt   = (nsz_x > count_x);
        status.idx_lt   = (idx_x < count_x);
        status.idx_over = (idx_x >= CAP_X);
        status.idx_gt   = (idx_x > count_x);
    end

    // ring slot of a front-relative position; sum stays below twice the capacity
    assign pos_x    = (cmd.addr_sel == rde_pkg::ADDR_INDEX) ? idx_x : count_x;
    assign sum      = SW'(front_reg) + SW'(pos_x);
    assign slot_pos = (sum >= CAP_S) ? PW'(sum - CAP_S) : PW'(sum);
    assign sum_one  = SW'(front_reg) + SW'(1);
    assign slot_one = (sum_one >= CAP_S) ? PW'(sum_one - CAP_S) : PW'(sum_one);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - PW'(1);
    assign addr = (cmd.addr_sel == rde_pkg::ADDR_FRONT_DEC) ? front_dec : slot_pos;

    assign word  = WORD_BITS'({32'b0, req_reg.value});
    assign wdata = cmd.wr_zero ? '0 : word;

    always_comb
    begin
        case (cmd.cnt_op)
            rde_pkg::CNT_INC:  count_next = count_reg + CW'(1);
            rde_pkg::CNT_DEC:  count_next = count_reg - CW'(1);
            rde_pkg::CNT_LOAD: count_next = CW'(req_reg.new_size);
            default:           count_next = count_reg;
        endcase
        case (cmd.front_op)
            rde_pkg::FR_DEC: front_next = front_dec;
            rde_pkg::FR_INC: front_next = slot_one;
            default:         front_next = front_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.mem_re)
        begin
            rd_reg <= mem[addr];
        end
    end

    assign rd_wide = 64'(rd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_reg.read_data <= cmd.rsp_use_rd ? signed'(rd_wide[31:0]) : '0;
            rsp_reg.status    <= cmd.rsp_status;
            rsp_reg.size_now  <= 11'(count_next);
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

[src/rde_ctrl.sv]
// Deque controller: request/response handshakes, per-op sequencing and the
// zero-fill loop. Drives rde_dp through cmd_t; uses rde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rde_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    input  rde_pkg::dp_status_t status,
    output rde_pkg::cmd_t       cmd
);

    rde_pkg::state_t state_reg;
    rde_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    logic            slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == rde_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rde_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.take_req   = 1'b0;
        cmd.mem_we     = 1'b0;
        cmd.mem_re     = 1'b0;
        cmd.addr_sel   = rde_pkg::ADDR_BACK;
        cmd.wr_zero    = 1'b0;
        cmd.cnt_op     = rde_pkg::CNT_HOLD;
        cmd.front_op   = rde_pkg::FR_HOLD;
        cmd.load_rsp   = 1'b0;
        cmd.rsp_status = rde_pkg::ST_OK;
        cmd.rsp_use_rd = 1'b0;

        case (state_reg)
            rde_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = rde_pkg::S_EXEC;
                end
            end

            rde_pkg::S_EXEC:
            begin
                case (status.op)
                    rde_pkg::OP_PUSH_TAIL, rde_pkg::OP_PUSH_FRONT:
                    begin
                        if (slot_free)
                        begin
                            cmd.load_rsp = 1'b1;
                            state_next   = rde_pkg::S_IDLE;
                            if (status.full)
                            begin
                                cmd.rsp_status = rde_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.mem_we = 1'b1;
                                cmd.cnt_op = rde_pkg::CNT_INC;
                                if (status.op == rde_pkg::OP_PUSH_FRONT)
                                begin
                                    cmd.addr_sel = rde_pkg::ADDR_FRONT_DEC;
                                    cmd.front_op = rde_pkg::FR_DEC;
                                end
                            end
                        end
                    end

                    rde_pkg::OP_POP_HEAD, rde_pkg::OP_POP_BACK:
                    begin
                        if (slot_free)
                        begin
                            cmd.load_rsp = 1'b1;
                            state_next   = rde_pkg::S_IDLE;
                            if (status.empty)
                            begin
                                cmd.rsp_status = rde_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.cnt_op = rde_pkg::CNT_DEC;
                                if (status.op == rde_pkg::OP_POP_HEAD)
                                begin
                                    cmd.front_op = rde_pkg::FR_INC;
                                end
                            end
                        end
                    end

                    rde_pkg::OP_RESIZE:
                    begin
                        if (!status.nsz_over && status.nsz_gt)
                        begin
                            // grow: zero one slot at the tail per cycle
                            cmd.mem_we  = 1'b1;
                            cmd.wr_zero = 1'b1;
                            cmd.cnt_op  = rde_pkg::CNT_INC;
                        end
                        else if (slot_free)
                        begin
                            cmd.load_rsp = 1'b1;
                            state_next   = rde_pkg::S_IDLE;
                            if (status.nsz_over)
                            begin
                                cmd.rsp_status = rde_pkg::ST_RANGE;
                            end
                            else
                            begin
                                cmd.cnt_op = rde_pkg::CNT_LOAD;
                            end
                        end
                    end

                    rde_pkg::OP_READ:
                    begin
                        if (status.idx_lt)
                        begin
                            cmd.mem_re   = 1'b1;
                            cmd.addr_sel = rde_pkg::ADDR_INDEX;
                            state_next   = rde_pkg::S_READ;
                        end
                        else if (slot_free)
                        begin
                            cmd.load_rsp   = 1'b1;
                            cmd.rsp_status = rde_pkg::ST_RANGE;
                            state_next     = rde_pkg::S_IDLE;
                        end
                    end

                    rde_pkg::OP_WRITE:
                    begin
                        if (!status.idx_lt && !status.idx_over && status.idx_gt)
                        begin
                            // gap before the index: zero-fill at the tail
                            cmd.mem_we  = 1'b1;
                            cmd.wr_zero = 1'b1;
                            cmd.cnt_op  = rde_pkg::CNT_INC;
                        end
                        else if (slot_free)
                        begin
                            cmd.load_rsp = 1'b1;
                            state_next   = rde_pkg::S_IDLE;
                            if (status.idx_lt)
                            begin
                                cmd.mem_we   = 1'b1;
                                cmd.addr_sel = rde_pkg::ADDR_INDEX;
                            end
                            else if (status.idx_over)
                            begin
                                cmd.rsp_status = rde_pkg::ST_RANGE;
                            end
                            else
                            begin
                                // index equals count: append at the tail
                                cmd.mem_we = 1'b1;
                                cmd.cnt_op = rde_pkg::CNT_INC;
                            end
                        end
                    end

                    default:
                    begin
                        if (slot_free)
                        begin
                            cmd.load_rsp = 1'b1;
                            state_next   = rde_pkg::S_IDLE;
                        end
                    end
                endcase
            end

            rde_pkg::S_READ:
            begin
                if (slot_free)
                begin
                    cmd.load_rsp   = 1'b1;
                    cmd.rsp_use_rd = 1'b1;
                    state_next     = rde_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rde_pkg::S_IDLE;
            end
        endcase

        if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

endmodule

`default_nettype wire

[src/resizable_deque_engine_unit.sv]
// Resizable deque engine. An accepted request is registered and run in S_EXEC;
// an in-range read adds S_READ, and a growing resize or a write past the end
// first zero-fills the tail slots one at a time. A new request is accepted only
// in S_IDLE, once the previous one is done; the response register lets it be
// accepted while the previous response waits. Reset (rst_n, async) clears the
// front pointer, element count and handshake state; the ring store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module resizable_deque_engine_unit #(
    parameter int CAPACITY  = 1024,
    parameter int WORD_BITS = 32
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           req_valid,
    output logic          req_ready,
    input  rde_pkg::req_t req,
    output logic          rsp_valid,
    input  wire           rsp_ready,
    output rde_pkg::rsp_t rsp
);

    rde_pkg::dp_status_t dp_status;
    rde_pkg::cmd_t       cmd;

    rde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (dp_status),
        .cmd       (cmd)
    );

    rde_dp #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (dp_status),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire
